@@ sv/nntc_pkg.sv @@
// package for the nearest neighbor tour cost block: widths, codes, states
package nntc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int CMD_W    = 1;
  localparam int VERT_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int CFG_W    = 7;
  localparam int COST_W   = 22;

  localparam logic [CMD_W-1:0]  CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0]  CMD_RUN   = 1'b1;
  localparam logic [CFG_W-1:0]  COUNT_RESET = 7'd2;
  localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_CLOSE_RD,
    ST_CLOSE_ADD,
    ST_DONE
  } nntc_state_t;

endpackage

@@ sv/nearest_neighbour_tour_cost.sv @@
// greedy nearest neighbor tour cost over a stored weight matrix
//
//   channel  direction  ports
//   in       input      in_valid in_ready in_command in_row in_col in_weight in_start_vertex
//   out      output     out_valid out_ready out_tour_start out_tour_cost
//   cfg      input      cfg_valid cfg_ready cfg_data (vertex_count)
//
// write words are taken only while idle; a run scans each row of the weight memory
// through its single read port, one row entry a cycle
// reset clears control and visited flags at once; the weight memory has no clear
// a finished result waits in the output register while new words are taken
// a run with its start vertex out of range is taken and dropped
module nearest_neighbour_tour_cost
  import nntc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [VERT_W-1:0]   in_row,
  input  logic [VERT_W-1:0]   in_col,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [VERT_W-1:0]   in_start_vertex,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERT_W-1:0]   out_tour_start,
  output logic [COST_W-1:0]   out_tour_cost,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int VIDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W    = 2 * VIDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int ACC_W     = ((COST_W > WEIGHT_BITS) ? COST_W : WEIGHT_BITS) + 1;

  nntc_state_t state_r, state_nxt;

  logic [CFG_W-1:0]        count_r, count_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [VIDX_W-1:0]      cur_r, cur_nxt;
  logic [VIDX_W-1:0]      start_r, start_nxt;
  logic [VIDX_W-1:0]      idx_r, idx_nxt;
  logic [VIDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]       seen_r, seen_nxt;
  logic                   found_r, found_nxt;
  logic [WEIGHT_BITS-1:0] best_r, best_nxt;
  logic [VIDX_W-1:0]      pick_r, pick_nxt;
  logic [COST_W-1:0]      cost_r, cost_nxt;
  logic [VERT_W-1:0]      out_start_r, out_start_nxt;
  logic [COST_W-1:0]      out_cost_r, out_cost_nxt;

  logic [WEIGHT_BITS-1:0] mem [MEM_DEPTH];
  logic [WEIGHT_BITS-1:0] rd_data_r;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;

  logic [CNT_W-1:0]       n_eff;
  logic [VIDX_W-1:0]      n_last;
  logic                   in_acc;
  logic                   take;
  logic                   found_c;
  logic [WEIGHT_BITS-1:0] best_c;
  logic [VIDX_W-1:0]      pick_c;
  logic [WEIGHT_BITS-1:0] add_w;
  logic [ACC_W-1:0]       sum;
  logic [COST_W-1:0]      sum_sat;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_tour_start = out_start_r;
  assign out_tour_cost  = out_cost_r;
  assign in_acc = in_valid && in_ready;

  always_comb begin
    if (count_r < CFG_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (int'(count_r) > MAX_VERTICES) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(count_r);
    end
  end
  assign n_last = VIDX_W'(n_eff - 1'b1);

  // weight memory, one write and one registered read port
  assign wr_en   = in_acc && (in_command == CMD_WRITE) &&
                   (int'(in_row) < MAX_VERTICES) && (int'(in_col) < MAX_VERTICES);
  assign wr_addr = {VIDX_W'(in_row), VIDX_W'(in_col)};
  assign rd_en   = (state_r == ST_SCAN) || (state_r == ST_CLOSE_RD);
  assign rd_addr = (state_r == ST_CLOSE_RD) ? {cur_r, start_r} : {cur_r, idx_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= WEIGHT_BITS'(in_weight);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // candidate compare on returning row data
  assign take    = rd_vld_r && (rd_idx_r != cur_r) && !visited_r[rd_idx_r] &&
                   (!found_r || (rd_data_r < best_r));
  assign found_c = found_r || take;
  assign best_c  = take ? rd_data_r : best_r;
  assign pick_c  = take ? rd_idx_r : pick_r;

  // saturating cost add
  assign add_w   = (state_r == ST_STEP) ? best_c : rd_data_r;
  assign sum     = ACC_W'(cost_r) + ACC_W'(add_w);
  assign sum_sat = (sum > ACC_W'(COST_MAX)) ? COST_MAX : COST_W'(sum);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    visited_nxt   = visited_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    seen_nxt      = seen_r;
    found_nxt     = found_c;
    best_nxt      = best_c;
    pick_nxt      = pick_c;
    cost_nxt      = cost_r;
    out_start_nxt = out_start_r;
    out_cost_nxt  = out_cost_r;

    if (cfg_valid && cfg_ready) begin
      count_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_command == CMD_RUN) &&
            (CNT_W'(in_start_vertex) < n_eff) && (int'(in_start_vertex) < MAX_VERTICES)) begin
          visited_nxt = '0;
          visited_nxt[VIDX_W'(in_start_vertex)] = 1'b1;
          cur_nxt   = VIDX_W'(in_start_vertex);
          start_nxt = VIDX_W'(in_start_vertex);
          seen_nxt  = CNT_W'(1);
          cost_nxt  = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = idx_r;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == n_last) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        if (!found_c) begin
          state_nxt = ST_CLOSE_RD;
        end else begin
          cost_nxt = sum_sat;
          cur_nxt  = pick_c;
          visited_nxt[pick_c] = 1'b1;
          seen_nxt = seen_r + 1'b1;
          if (CNT_W'(seen_r + 1'b1) == n_eff) begin
            state_nxt = ST_CLOSE_RD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLOSE_RD: begin
        state_nxt = ST_CLOSE_ADD;
      end
      ST_CLOSE_ADD: begin
        cost_nxt  = sum_sat;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = VERT_W'(start_r);
          out_cost_nxt  = cost_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= COUNT_RESET;
      visited_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      visited_r   <= visited_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    start_r     <= start_nxt;
    idx_r       <= idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    seen_r      <= seen_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
    cost_r      <= cost_nxt;
    out_start_r <= out_start_nxt;
    out_cost_r  <= out_cost_nxt;
  end

endmodule

@@ sim/testbench.sv @@
// testbench for the nearest neighbor tour cost block: greedy tour prediction and result checks
`timescale 1ns / 100ps

module testbench;
  import nntc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int SQUARE = MAX_VERTICES_DEF * MAX_VERTICES_DEF;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [VERT_W-1:0]   row;
    logic [VERT_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
    logic [VERT_W-1:0]   start_vertex;
  } tour_word_t;

  typedef struct {
    logic [VERT_W-1:0] tour_start;
    logic [COST_W-1:0] tour_cost;
  } tour_result_t;

  typedef enum {FILL_FLAT, FILL_NARROW, FILL_WIDE} fill_style_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = CMD_WRITE;
  logic [VERT_W-1:0]   in_row = '0;
  logic [VERT_W-1:0]   in_col = '0;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic [VERT_W-1:0]   in_start_vertex = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VERT_W-1:0]   out_tour_start;
  logic [COST_W-1:0]   out_tour_cost;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  logic [WEIGHT_W-1:0] weight_copy [SQUARE];
  logic [CFG_W-1:0]    vertex_count_copy = COUNT_RESET;
  tour_word_t          queued_words [$];
  tour_result_t        expected_tours [$];
  tour_word_t          held_word;

  int gap_left = 0;
  int sender_calm = 0;
  int ready_hold = 0;
  int mismatch_count = 0;
  int tours_checked = 0;
  int write_count = 0;
  int dropped_runs = 0;
  int gen_filled = 0;
  int gen_active = 2;

  nearest_neighbour_tour_cost u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_weight      (in_weight),
    .in_start_vertex(in_start_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tour_start (out_tour_start),
    .out_tour_cost  (out_tour_cost),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int active_vertices(input logic [CFG_W-1:0] count);
    if (count < 2) return 2;
    if (count > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return count;
  endfunction

  function automatic tour_result_t greedy_tour_cost(input logic [VERT_W-1:0] origin,
                                                    input int n);
    tour_result_t res;
    logic [MAX_VERTICES_DEF-1:0] visited;
    logic [WEIGHT_W-1:0] best;
    logic [WEIGHT_W-1:0] w;
    logic found;
    int cur;
    int pick;
    longint total;
    visited = '0;
    visited[origin] = 1'b1;
    cur = origin;
    total = 0;
    for (int seen = 1; seen < n; seen++) begin
      found = 1'b0;
      best = '0;
      pick = cur;
      for (int i = 0; i < n; i++) begin
        w = weight_copy[cur * MAX_VERTICES_DEF + i];
        if (i != cur && !visited[i] && (!found || w < best)) begin
          found = 1'b1;
          best = w;
          pick = i;
        end
      end
      total += best;
      cur = pick;
      visited[cur] = 1'b1;
    end
    total += weight_copy[cur * MAX_VERTICES_DEF + origin];
    if (total > COST_MAX) total = COST_MAX;
    res.tour_start = origin;
    res.tour_cost = total[COST_W-1:0];
    return res;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(input fill_style_t style);
    int roll;
    roll = $urandom_range(0, 9);
    if (style == FILL_FLAT) return 16'd9;
    if (style == FILL_NARROW) return WEIGHT_W'($urandom_range(0, 3));
    if (roll == 0) return '0;
    if (roll == 1) return {WEIGHT_W{1'b1}};
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  task automatic push_write(input int r, input int c, input int w);
    tour_word_t wd;
    wd.command = CMD_WRITE;
    wd.row = VERT_W'(r);
    wd.col = VERT_W'(c);
    wd.weight = WEIGHT_W'(w);
    wd.start_vertex = VERT_W'($urandom_range(0, 63));
    queued_words.push_back(wd);
  endtask

  task automatic push_run(input int origin);
    tour_word_t wd;
    wd.command = CMD_RUN;
    wd.row = VERT_W'($urandom_range(0, 63));
    wd.col = VERT_W'($urandom_range(0, 63));
    wd.weight = WEIGHT_W'($urandom_range(0, 65535));
    wd.start_vertex = VERT_W'(origin);
    queued_words.push_back(wd);
  endtask

  task automatic fill_block(input int m, input fill_style_t style);
    for (int r = 0; r < m; r++)
      for (int c = 0; c < m; c++)
        push_write(r, c, pick_weight(style));
    if (m > gen_filled) gen_filled = m;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_words.size() != 0 || in_valid || expected_tours.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_vertex_count(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_count_copy = value;
    gen_active = active_vertices(value);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : word_driver
    int roll;
    int n;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      sender_calm = 0;
    end else begin
      if (in_valid && in_ready) begin
        n = active_vertices(vertex_count_copy);
        if (held_word.command == CMD_WRITE) begin
          weight_copy[{held_word.row, held_word.col}] = held_word.weight;
          write_count++;
        end else if (held_word.start_vertex < n) begin
          expected_tours.push_back(greedy_tour_cost(held_word.start_vertex, n));
        end else begin
          dropped_runs++;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && queued_words.size() != 0) begin
          held_word = queued_words.pop_front();
          in_valid <= 1'b1;
          in_command <= held_word.command;
          in_row <= held_word.row;
          in_col <= held_word.col;
          in_weight <= held_word.weight;
          in_start_vertex <= held_word.start_vertex;
          if (sender_calm > 0) begin
            sender_calm--;
            gap_left = 0;
          end else begin
            roll = $urandom_range(0, 99);
            if (roll < 5) sender_calm = $urandom_range(10, 40);
            if (roll < 50) gap_left = 0;
            else if (roll < 88) gap_left = $urandom_range(1, 3);
            else if (roll < 97) gap_left = $urandom_range(4, 10);
            else gap_left = $urandom_range(15, 40);
          end
        end else begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    tour_result_t want;
    int roll;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tours.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected tour word: start %0d cost %0d", out_tour_start, out_tour_cost);
        end else begin
          want = expected_tours.pop_front();
          tours_checked++;
          if (out_tour_start !== want.tour_start || out_tour_cost !== want.tour_cost) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("tour mismatch: expected start %0d cost %0d, got start %0d cost %0d",
                       want.tour_start, want.tour_cost, out_tour_start, out_tour_cost);
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          out_ready <= 1'b1;
          ready_hold = $urandom_range(10, 40);
        end else if (roll < 40) begin
          out_ready <= 1'b0;
          ready_hold = $urandom_range(0, 3);
        end else if (roll < 44) begin
          out_ready <= 1'b0;
          ready_hold = $urandom_range(15, 40);
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] batch_counts [6];
    fill_style_t style;
    int n;
    int roll;
    batch_counts = '{7'd4, 7'd2, 7'd1, 7'd6, 7'd5, 7'd3};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two vertices at reset count, extreme weights
    push_write(0, 0, {WEIGHT_W{1'b1}});
    push_write(0, 1, {WEIGHT_W{1'b1}});
    push_write(1, 0, '0);
    push_write(1, 1, '0);
    gen_filled = 2;
    push_run(0);
    push_run(1);
    push_run(2);
    push_run(63);
    push_write(63, 63, {WEIGHT_W{1'b1}});
    push_write(63, 0, 16'h5555);
    push_write(0, 63, 16'hAAAA);
    wait_drained();

    // counts below two act as two
    set_vertex_count(7'd0);
    push_run(1);
    push_run(2);
    wait_drained();
    set_vertex_count(7'd1);
    push_run(0);
    wait_drained();

    // all weights equal, lowest index wins
    set_vertex_count(7'd3);
    fill_block(3, FILL_FLAT);
    push_run(0);
    push_run(1);
    push_run(2);
    push_run(3);
    wait_drained();

    for (int b = 0; b < 6; b++) begin
      set_vertex_count(batch_counts[b]);
      n = gen_active;
      style = (b % 2 == 0) ? FILL_NARROW : FILL_WIDE;
      if (n > gen_filled) fill_block(n, style);
      for (int k = 0; k < 10; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40)
          push_write($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight(style));
        else if (roll < 50)
          push_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535));
        else if (roll < 90)
          push_run($urandom_range(0, n - 1));
        else
          push_run($urandom_range(n, 63));
        if (b == 3 && k == 5) wait_drained();
      end
      wait_drained();
    end

    $display("checked %0d greedy tours, %0d weight writes, %0d runs dropped (start out of range)",
             tours_checked, write_count, dropped_runs);
    $display("vertex counts from 0 to 6 applied, tours over 2 to 6 vertices with ties and extremes");
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/nntc_pkg.sv
sv/nearest_neighbour_tour_cost.sv
sim/testbench.sv
